FILE: design/assert_macros.svh
// Assertion macros used by the checker in tspf_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tspf_pkg.sv
// Constants for the transport stream PID filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tspf_pkg;

    localparam int PACKET_BYTES = 188;
    localparam int POS_W        = $clog2(PACKET_BYTES);
    localparam int OFS_W        = $clog2(PACKET_BYTES + 1);
    localparam int PID_W        = 13;

    localparam logic [7:0] SYNC_BYTE    = 8'h47;
    localparam logic [7:0] FLAG_ADAPT   = 8'h20;
    localparam logic [7:0] FLAG_PAYLOAD = 8'h10;
    localparam logic [7:0] FLAG_USTART  = 8'h40;
    localparam logic [PID_W-1:0] PID_RESET = 13'h1100;

    // Largest adaptation field length that still fits in the packet.
    localparam logic [7:0] ADAPT_MAX = 8'(PACKET_BYTES - 5);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_BYTES - 1);
    localparam logic [OFS_W-1:0] OFS_HDR  = OFS_W'(4);

    // tuser bit positions on the output side
    localparam int TUSER_USTART = 0;
    localparam int TUSER_FIRST  = 1;
    localparam int TUSER_W      = 2;

endpackage

`default_nettype wire

FILE: design/ts_packet_pid_filter.sv
// Output: a payload byte appears from the output register in the cycle after its input transfer.
// Throughput: one byte per cycle; the output register frees s_axis_tready whenever
// it is empty or being drained in the same cycle.
// Reset: hunting for sync, output empty, wanted PID 0x1100.
// Depends on tspf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ts_packet_pid_filter (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_wr_en,
    input  wire [tspf_pkg::PID_W-1:0]   cfg_wr_data,    // wanted_pid
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire [7:0]                   s_axis_tdata,   // ts_byte
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // payload_byte
    output logic [tspf_pkg::TUSER_W-1:0] m_axis_tuser,  // unit_start, first_of_packet
    output logic                        m_axis_tlast    // last_of_packet
);

    logic [tspf_pkg::PID_W-1:0] pid_reg;
    logic [tspf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       in_pkt_reg, in_pkt_next;
    logic [4:0]                 pid_hi_reg, pid_hi_next;
    logic                       ustart_reg, ustart_next;
    logic                       match_reg, match_next;
    logic                       pay_reg, pay_next;
    logic                       adapt_reg, adapt_next;
    logic [tspf_pkg::OFS_W-1:0] ofs_reg, ofs_next;

    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_data_reg;
    logic                       out_ustart_reg, out_first_reg, out_last_reg;

    logic                       accept;
    logic                       last;
    logic                       emit;
    logic [tspf_pkg::PID_W-1:0] pid_rx;
    logic [tspf_pkg::OFS_W-1:0] pos_ext;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign last    = (pos_reg >= tspf_pkg::POS_LAST);
    assign pos_ext = tspf_pkg::OFS_W'(pos_reg);
    assign pid_rx  = {pid_hi_reg, s_axis_tdata};

    always_comb
    begin
        pos_next    = pos_reg;
        in_pkt_next = in_pkt_reg;
        pid_hi_next = pid_hi_reg;
        ustart_next = ustart_reg;
        match_next  = match_reg;
        pay_next    = pay_reg;
        adapt_next  = adapt_reg;
        ofs_next    = ofs_reg;
        emit        = 1'b0;

        if (accept)
        begin
            if (!in_pkt_reg)
            begin
                if (s_axis_tdata == tspf_pkg::SYNC_BYTE)
                begin
                    in_pkt_next = 1'b1;
                    pos_next    = tspf_pkg::POS_W'(1);
                    pid_hi_next = '0;
                    ustart_next = 1'b0;
                    match_next  = 1'b0;
                    pay_next    = 1'b0;
                    adapt_next  = 1'b0;
                    ofs_next    = tspf_pkg::OFS_HDR;
                end
            end
            else
            begin
                priority if (pos_reg == tspf_pkg::POS_W'(1))
                begin
                    pid_hi_next = s_axis_tdata[4:0];
                    ustart_next = |(s_axis_tdata & tspf_pkg::FLAG_USTART);
                end
                else if (pos_reg == tspf_pkg::POS_W'(2))
                begin
                    match_next = (pid_rx == pid_reg);
                end
                else if (pos_reg == tspf_pkg::POS_W'(3))
                begin
                    adapt_next = |(s_axis_tdata & tspf_pkg::FLAG_ADAPT);
                    pay_next   = |(s_axis_tdata & tspf_pkg::FLAG_PAYLOAD);
                end
                else if (pos_reg == tspf_pkg::POS_W'(4) && adapt_reg)
                begin
                    // adaptation field running past the packet end drops the packet
                    if (s_axis_tdata > tspf_pkg::ADAPT_MAX)
                        match_next = 1'b0;
                    else
                        ofs_next = tspf_pkg::OFS_W'(5) + tspf_pkg::OFS_W'(s_axis_tdata);
                end
                else
                begin
                    emit = (pos_ext >= ofs_reg) && match_reg && pay_reg;
                end

                if (last)
                begin
                    in_pkt_next = 1'b0;
                    pos_next    = '0;
                end
                else
                begin
                    pos_next = pos_reg + tspf_pkg::POS_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = emit;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pid_reg       <= tspf_pkg::PID_RESET;
            pos_reg       <= '0;
            in_pkt_reg    <= 1'b0;
            pid_hi_reg    <= '0;
            ustart_reg    <= 1'b0;
            match_reg     <= 1'b0;
            pay_reg       <= 1'b0;
            adapt_reg     <= 1'b0;
            ofs_reg       <= tspf_pkg::OFS_HDR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                pid_reg <= cfg_wr_data;
            pos_reg       <= pos_next;
            in_pkt_reg    <= in_pkt_next;
            pid_hi_reg    <= pid_hi_next;
            ustart_reg    <= ustart_next;
            match_reg     <= match_next;
            pay_reg       <= pay_next;
            adapt_reg     <= adapt_next;
            ofs_reg       <= ofs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload of the output register, loaded on every input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg   <= s_axis_tdata;
            out_ustart_reg <= ustart_reg;
            out_first_reg  <= (pos_ext == ofs_reg);
            out_last_reg   <= last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_first_reg, out_ustart_reg};

endmodule

`default_nettype wire

FILE: design/tspf_checker.sv
// Port-level checks for ts_packet_pid_filter, attached by bind.
// Depends on assert_macros.svh and tspf_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tspf_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          s_axis_tvalid,
    input wire                          s_axis_tready,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [7:0]                    m_axis_tdata,
    input wire [tspf_pkg::TUSER_W-1:0]  m_axis_tuser,
    input wire                          m_axis_tlast
);

    // a stalled result holds its value
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output changed")

    // an empty output register never blocks the input
    `ASSERT_IMPL(a_ready_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

    // input taken while a result waits only if that result drains now
    `ASSERT_IMPL(a_ready_drain, clk, rst_n, s_axis_tready && m_axis_tvalid, m_axis_tready, "input taken over a held result")

    // a new result comes only from an input transfer in the previous cycle
    `ASSERT_IMPL(a_out_source, clk, rst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready), "result without input transfer")

endmodule

bind ts_packet_pid_filter tspf_checker u_tspf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: tb/pid_filter_checker.sv
// Checker for ts_packet_pid_filter: follows byte and payload transfers, predicts
// the filtered payload stream and compares it beat by beat.
// Depends on tspf_pkg.
`timescale 1ns / 1ps

module pid_filter_checker (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_wr_en,
    input  wire [tspf_pkg::PID_W-1:0]    cfg_wr_data,
    input  wire                          s_axis_tvalid,
    input  wire                          s_axis_tready,
    input  wire [7:0]                    s_axis_tdata,
    input  wire                          m_axis_tvalid,
    input  wire                          m_axis_tready,
    input  wire [7:0]                    m_axis_tdata,
    input  wire [tspf_pkg::TUSER_W-1:0]  m_axis_tuser,
    input  wire                          m_axis_tlast,
    output int                           failures,
    output int                           pending
);

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       unit_start;
        logic       first_of_packet;
        logic       last_of_packet;
    } payload_beat_t;

    payload_beat_t      beats_due[$];

    logic [tspf_pkg::PID_W-1:0] wanted_pid;
    logic [7:0]         byte_pos;
    logic               in_packet;
    logic [7:0]         hdr_flags;
    logic               pid_hit;
    logic               has_payload;
    logic               has_adapt;
    logic [7:0]         payload_start;

    task automatic clear_filter_state();
        byte_pos      = 8'd0;
        in_packet     = 1'b0;
        hdr_flags     = 8'd0;
        pid_hit       = 1'b0;
        has_payload   = 1'b0;
        has_adapt     = 1'b0;
        payload_start = 8'd4;
    endtask

    // Runs one stream byte through the filter state; queues a beat if one is due.
    task automatic filter_byte(input logic [7:0] b);
        logic [7:0]    pos;
        logic          last;
        payload_beat_t beat;
        if (!in_packet)
        begin
            if (b == tspf_pkg::SYNC_BYTE)
            begin
                clear_filter_state();
                in_packet = 1'b1;
                byte_pos  = 8'd1;
            end
            return;
        end
        pos  = byte_pos;
        last = (pos >= 8'(tspf_pkg::PACKET_BYTES - 1));
        if (pos == 8'd1)
            hdr_flags = b;
        else if (pos == 8'd2)
            pid_hit = ({hdr_flags[4:0], b} == wanted_pid);
        else if (pos == 8'd3)
        begin
            has_adapt   = (b & tspf_pkg::FLAG_ADAPT) != 8'd0;
            has_payload = (b & tspf_pkg::FLAG_PAYLOAD) != 8'd0;
        end
        else if (pos == 8'd4 && has_adapt)
        begin
            // adaptation field running past the packet end kills the packet
            if (b > tspf_pkg::ADAPT_MAX)
                pid_hit = 1'b0;
            else
                payload_start = 8'd5 + b;
        end
        else if (pos >= 8'd4 && pos >= payload_start && pid_hit && has_payload)
        begin
            beat.payload_byte    = b;
            beat.unit_start      = (hdr_flags & tspf_pkg::FLAG_USTART) != 8'd0;
            beat.first_of_packet = (pos == payload_start);
            beat.last_of_packet  = last;
            beats_due.push_back(beat);
        end
        if (last)
        begin
            in_packet = 1'b0;
            byte_pos  = 8'd0;
        end
        else
            byte_pos = pos + 8'd1;
    endtask

    task automatic check_beat();
        payload_beat_t want;
        if (beats_due.size() == 0)
        begin
            $error("unexpected payload transfer: tdata %0h tuser %0b tlast %0b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
            failures++;
            return;
        end
        want = beats_due.pop_front();
        if (m_axis_tdata !== want.payload_byte)
        begin
            $error("payload_byte: expected %0h, actual %0h", want.payload_byte, m_axis_tdata);
            failures++;
        end
        if (m_axis_tuser[tspf_pkg::TUSER_USTART] !== want.unit_start)
        begin
            $error("unit_start: expected %0b, actual %0b", want.unit_start,
                   m_axis_tuser[tspf_pkg::TUSER_USTART]);
            failures++;
        end
        if (m_axis_tuser[tspf_pkg::TUSER_FIRST] !== want.first_of_packet)
        begin
            $error("first_of_packet: expected %0b, actual %0b", want.first_of_packet,
                   m_axis_tuser[tspf_pkg::TUSER_FIRST]);
            failures++;
        end
        if (m_axis_tlast !== want.last_of_packet)
        begin
            $error("last_of_packet: expected %0b, actual %0b", want.last_of_packet,
                   m_axis_tlast);
            failures++;
        end
    endtask

    // Inputs only move at the rising edge, so the falling edge sees exactly
    // what the next rising edge will transfer.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            clear_filter_state();
            wanted_pid = tspf_pkg::PID_RESET;
            beats_due.delete();
            failures   = 0;
        end
        else
        begin
            if (m_axis_tvalid === 1'b1 && m_axis_tready)
                check_beat();
            if (cfg_wr_en)
                wanted_pid = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready === 1'b1)
                filter_byte(s_axis_tdata);
        end
        pending = beats_due.size();
    end

endmodule

FILE: tb/tb.sv
// Top of the ts_packet_pid_filter testbench: clock, reset, byte stream stimulus,
// output back-pressure and the verdict.
// Depends on tspf_pkg, ts_packet_pid_filter and pid_filter_checker.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [tspf_pkg::PID_W-1:0]   cfg_wr_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'd0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;
    logic [tspf_pkg::TUSER_W-1:0] m_axis_tuser;
    logic               m_axis_tlast;

    int                 failures;
    int                 pending;
    int                 cycles = 0;
    int                 stall_left = 0;
    bit                 src_idle_en = 1'b0;
    bit                 sink_idle_en = 1'b0;

    always #10 clk = ~clk;

    ts_packet_pid_filter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    pid_filter_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .failures      (failures),
        .pending       (pending)
    );

    // payload sink back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (sink_idle_en && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 9);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("ts_packet_pid_filter verification failed");
            $finish;
        end
    end

    // Returns right after the transfer edge; the caller drives the next byte
    // or drops tvalid in the same step.
    task automatic send_byte(input logic [7:0] b);
        if (src_idle_en && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(negedge clk);
        while (!s_axis_tready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_packet(input logic [tspf_pkg::PID_W-1:0] pid, input bit ustart,
                               input bit adapt, input bit payload,
                               input logic [7:0] adapt_len, input bit sync_fill);
        logic [7:0] body;
        send_byte(tspf_pkg::SYNC_BYTE);
        // error and priority bits are random, the block ignores them
        send_byte((8'($urandom) & 8'hA0) | (ustart ? tspf_pkg::FLAG_USTART : 8'h00) |
                  8'(pid[12:8]));
        send_byte(pid[7:0]);
        send_byte((8'($urandom) & 8'hCF) | (adapt ? tspf_pkg::FLAG_ADAPT : 8'h00) |
                  (payload ? tspf_pkg::FLAG_PAYLOAD : 8'h00));
        for (int pos = 4; pos < tspf_pkg::PACKET_BYTES; pos++)
        begin
            if (pos == 4 && adapt)
                body = adapt_len;
            else if (sync_fill || $urandom_range(0, 15) == 0)
                body = tspf_pkg::SYNC_BYTE;
            else
                body = 8'($urandom);
            send_byte(body);
        end
    endtask

    // Bytes while hunting; a stray sync byte now and then misaligns the stream.
    task automatic send_noise(input int count);
        logic [7:0] b;
        repeat (count)
        begin
            b = 8'($urandom);
            if (b == tspf_pkg::SYNC_BYTE && $urandom_range(0, 3) != 0)
                b = ~b;
            send_byte(b);
        end
    endtask

    task automatic send_random_packet(input logic [tspf_pkg::PID_W-1:0] want);
        logic [tspf_pkg::PID_W-1:0] pid;
        logic [7:0]       alen;
        int               pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            pid = want;
        else if (pick < 8)
            pid = want ^ (13'd1 << $urandom_range(0, tspf_pkg::PID_W - 1));
        else
            pid = 13'($urandom);
        pick = $urandom_range(0, 15);
        if (pick < 11)
            alen = 8'($urandom_range(0, 20));
        else if (pick < 14)
            alen = 8'($urandom_range(150, tspf_pkg::ADAPT_MAX));
        else
            alen = 8'($urandom_range(tspf_pkg::ADAPT_MAX + 1, 255));
        send_packet(pid, $urandom_range(0, 1), $urandom_range(0, 2) == 0,
                    $urandom_range(0, 7) != 0, alen, $urandom_range(0, 15) == 0);
    endtask

    // Holds the stream off until every predicted beat has been transferred.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_wanted(input logic [tspf_pkg::PID_W-1:0] pid);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pid;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        logic [tspf_pkg::PID_W-1:0] want;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;

        // reset PID; garbage before sync is dropped
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h46);
        send_byte(8'h48);
        send_byte(8'hB8);
        send_packet(tspf_pkg::PID_RESET, 1'b1, 1'b1, 1'b1, 8'd3, 1'b0);
        settle();

        // adaptation field leaves a single payload byte
        set_wanted(13'h1FFF);
        send_noise($urandom_range(1, 10));
        send_packet(13'h1FFF, 1'b0, 1'b1, 1'b1, tspf_pkg::ADAPT_MAX - 8'd1, 1'b0);
        settle();

        // last part runs without idling
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        want = 13'($urandom);
        set_wanted(want);
        send_noise($urandom_range(1, 10));
        send_random_packet(want);
        settle();

        if (failures == 0 && pending == 0)
            $display("ts_packet_pid_filter verification clean");
        else
            $display("ts_packet_pid_filter verification failed");
        $finish;
    end

endmodule

FILE: ts_packet_pid_filter.f
+incdir+design
design/tspf_pkg.sv
design/ts_packet_pid_filter.sv
design/tspf_checker.sv
tb/pid_filter_checker.sv
tb/tb.sv
